FILE: rtl/core/vfm_pkg.sv
`default_nettype none

package vfm_pkg;

  localparam int unsigned NumFaults = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // Fault bit positions in fault_flags and new_faults.
  localparam int unsigned FltLink  = 0;
  localparam int unsigned FltBatt  = 1;
  localparam int unsigned FltLeak  = 2;
  localparam int unsigned FltDepth = 3;
  localparam int unsigned FltPitch = 4;
  localparam int unsigned FltStall = 5;

  // Reciprocal of ten scaled by 2^16; exact for magnitudes below 16384.
  localparam logic [12:0] PitchRecip = 13'd6554;
  localparam int unsigned PitchShift = 16;

  localparam logic [15:0] LinkTimeoutRst = 16'd1000;
  localparam logic [15:0] BattFloorRst   = 16'd3300;
  localparam logic [13:0] DepthLimitRst  = 14'd1000;
  localparam logic [7:0]  PitchLimitRst  = 8'd45;
  localparam logic [7:0]  StallLimitRst  = 8'd10;
  localparam logic [15:0] BlinkNormalRst = 16'd500;
  localparam logic [15:0] BlinkAlarmRst  = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINK_TIMEOUT = 3'd0,
    REG_BATT_FLOOR   = 3'd1,
    REG_DEPTH_LIMIT  = 3'd2,
    REG_PITCH_LIMIT  = 3'd3,
    REG_STALL_LIMIT  = 3'd4,
    REG_BLINK_NORMAL = 3'd5,
    REG_BLINK_ALARM  = 3'd6
  } vfm_reg_e;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [31:0]        last_link_ms;
    logic [15:0]        battery_mv;
    logic               leak_seen;
    logic [13:0]        depth_level;
    logic signed [11:0] pitch_tenths;
    logic [31:0]        heartbeat;
  } vfm_in_t;

  typedef struct packed {
    logic [NumFaults-1:0] fault_flags;
    logic [NumFaults-1:0] new_faults;
    logic                 link_restored;
    logic                 stall_blow;
    logic                 emergency_blow;
    logic                 emergency;
    logic                 led_on;
  } vfm_out_t;

  typedef struct packed {
    logic [15:0] link_timeout_ms;
    logic [15:0] battery_floor_mv;
    logic [13:0] depth_limit_cm;
    logic [7:0]  pitch_limit_deg;
    logic [7:0]  stall_limit;
    logic [15:0] blink_normal_ms;
    logic [15:0] blink_alarm_ms;
  } vfm_cfg_t;

  typedef struct packed {
    logic [NumFaults-1:0] fault_bits;
    logic                 emergency_latched;
    logic [7:0]           stall_ticks;
    logic [31:0]          prior_heartbeat;
    logic                 led_level;
    logic [31:0]          last_toggle_ms;
  } vfm_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/vfm_tick.sv
`default_nettype none

module vfm_tick import vfm_pkg::*; (
  input  wire vfm_in_t    item_i,
  input  wire vfm_cfg_t   cfg_i,
  input  wire vfm_state_t state_i,
  output vfm_state_t      state_o,
  output vfm_out_t        result_o
);

  logic [31:0]          link_age;
  logic [31:0]          blink_age;
  logic [11:0]          pitch_mag;
  logic [24:0]          pitch_prod;
  logic [8:0]           pitch_whole;
  logic                 hb_same;
  logic [7:0]           ticks_inc;
  logic                 restored;
  logic                 stall_set;
  logic [NumFaults-1:0] flt;
  logic                 emerg_set;
  logic                 emerg;
  logic [15:0]          interval;
  logic                 toggle;

  assign link_age    = item_i.now_ms - item_i.last_link_ms;
  assign pitch_mag   = item_i.pitch_tenths[11] ? 12'(-item_i.pitch_tenths)
                                               : 12'(item_i.pitch_tenths);
  assign pitch_prod  = 25'(pitch_mag) * 25'(PitchRecip);
  assign pitch_whole = pitch_prod[PitchShift+8:PitchShift];
  assign hb_same     = (item_i.heartbeat == state_i.prior_heartbeat);
  assign ticks_inc   = (state_i.stall_ticks == 8'hFF) ? 8'hFF : state_i.stall_ticks + 8'd1;

  always_comb begin
    flt       = state_i.fault_bits;
    restored  = 1'b0;
    stall_set = 1'b0;

    if (link_age > {16'd0, cfg_i.link_timeout_ms}) begin
      flt[FltLink] = 1'b1;
    end else if (state_i.fault_bits[FltLink]) begin
      flt[FltLink] = 1'b0;
      restored     = 1'b1;
    end

    if (item_i.battery_mv < cfg_i.battery_floor_mv) flt[FltBatt] = 1'b1;
    if (item_i.leak_seen) flt[FltLeak] = 1'b1;
    if (item_i.depth_level > cfg_i.depth_limit_cm) flt[FltDepth] = 1'b1;
    if (pitch_whole > {1'b0, cfg_i.pitch_limit_deg}) flt[FltPitch] = 1'b1;

    // A changed heartbeat clears the stall fault; an unchanged one counts up.
    if (hb_same) begin
      if (ticks_inc > cfg_i.stall_limit && !state_i.fault_bits[FltStall]) begin
        flt[FltStall] = 1'b1;
        stall_set     = 1'b1;
      end
    end else begin
      flt[FltStall] = 1'b0;
    end
  end

  assign emerg_set = (flt != '0) && !state_i.emergency_latched;
  assign emerg     = state_i.emergency_latched | emerg_set;
  assign interval  = emerg ? cfg_i.blink_alarm_ms : cfg_i.blink_normal_ms;
  assign blink_age = item_i.now_ms - state_i.last_toggle_ms;
  assign toggle    = (blink_age >= {16'd0, interval});

  always_comb begin
    state_o.fault_bits        = flt;
    state_o.emergency_latched = emerg;
    state_o.stall_ticks       = hb_same ? ticks_inc : 8'd0;
    state_o.prior_heartbeat   = item_i.heartbeat;
    state_o.led_level         = state_i.led_level ^ toggle;
    state_o.last_toggle_ms    = toggle ? item_i.now_ms : state_i.last_toggle_ms;
  end

  always_comb begin
    result_o.fault_flags    = flt;
    result_o.new_faults     = flt & ~state_i.fault_bits;
    result_o.link_restored  = restored;
    result_o.stall_blow     = stall_set;
    result_o.emergency_blow = emerg_set;
    result_o.emergency      = emerg;
    result_o.led_on         = state_i.led_level ^ toggle;
  end

endmodule

`default_nettype wire

FILE: rtl/core/vehicle_fault_monitor.sv
// An accepted item waits in the input register; its result is registered in the result register.
// Throughput: one item per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// The monitor state lives in one stage, so each tick sees all earlier ticks.
// Reset clears the fault state, the LED, the counters and both valid flags,
// and loads the default configuration. Configuration writes are registered.
`default_nettype none

module vehicle_fault_monitor import vfm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire vfm_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output vfm_out_t                 out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  vfm_in_t    in_q;
  logic       in_valid_q;
  vfm_out_t   out_q;
  vfm_out_t   out_d;
  logic       out_valid_q;
  vfm_state_t st_q;
  vfm_state_t st_d;
  vfm_cfg_t   cfg_q;
  logic       advance;
  logic       in_fire;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  vfm_tick u_tick (
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .state_o  (st_d),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_data_i;
    if (advance) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link_timeout_ms  <= LinkTimeoutRst;
      cfg_q.battery_floor_mv <= BattFloorRst;
      cfg_q.depth_limit_cm   <= DepthLimitRst;
      cfg_q.pitch_limit_deg  <= PitchLimitRst;
      cfg_q.stall_limit      <= StallLimitRst;
      cfg_q.blink_normal_ms  <= BlinkNormalRst;
      cfg_q.blink_alarm_ms   <= BlinkAlarmRst;
    end else if (cfg_valid_i) begin
      unique case (vfm_reg_e'(cfg_index_i))
        REG_LINK_TIMEOUT: cfg_q.link_timeout_ms  <= cfg_data_i;
        REG_BATT_FLOOR:   cfg_q.battery_floor_mv <= cfg_data_i;
        REG_DEPTH_LIMIT:  cfg_q.depth_limit_cm   <= cfg_data_i[13:0];
        REG_PITCH_LIMIT:  cfg_q.pitch_limit_deg  <= cfg_data_i[7:0];
        REG_STALL_LIMIT:  cfg_q.stall_limit      <= cfg_data_i[7:0];
        REG_BLINK_NORMAL: cfg_q.blink_normal_ms  <= cfg_data_i;
        REG_BLINK_ALARM:  cfg_q.blink_alarm_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/vfm_checker.sv
`default_nettype none

module vfm_checker import vfm_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire vfm_out_t out_data_o
);

  // With the result register empty the block must always take an item.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the result register is empty");

  // Emergency is latched: once shown, every later item shows it too.
  a_emergency_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.emergency |=> !out_valid_o || out_data_o.emergency)
    else $error("emergency dropped after being latched");

  a_new_in_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.new_faults & ~out_data_o.fault_flags) == '0)
    else $error("a new fault is missing from the fault flags");

  a_blow_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.emergency_blow |->
      out_data_o.emergency && (out_data_o.fault_flags != '0))
    else $error("emergency latched without a fault");

  // A stalled result register keeps its item.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

endmodule

bind vehicle_fault_monitor vfm_checker u_vfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
